// ===== src/ossm_pkg.sv =====
// ----------------------------------------------------------------------------
// ossm_pkg
// Types and codes shared by the order slot state manager: item structs,
// slot record, slot status codes, request kinds and exchange response codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ossm_pkg;

    // Slot status codes
    localparam logic [2:0] SLOT_INVALID        = 3'd0;
    localparam logic [2:0] SLOT_PENDING_NEW    = 3'd1;
    localparam logic [2:0] SLOT_LIVE           = 3'd2;
    localparam logic [2:0] SLOT_PENDING_CANCEL = 3'd3;
    localparam logic [2:0] SLOT_DEAD           = 3'd4;

    // Item source
    localparam logic FUNC_MOVE     = 1'b0;
    localparam logic FUNC_RESPONSE = 1'b1;

    // Request kinds
    localparam logic REQ_NEW    = 1'b0;
    localparam logic REQ_CANCEL = 1'b1;

    // Exchange response codes
    localparam logic [2:0] RSP_ACCEPTED = 3'd0;
    localparam logic [2:0] RSP_CANCELED = 3'd1;
    localparam logic [2:0] RSP_FILLED   = 3'd2;

    localparam logic [31:0] NO_PRICE       = 32'hFFFF_FFFF;
    localparam logic [31:0] FIRST_ORDER_ID = 32'd1;

    typedef struct packed {
        logic        func;
        logic [2:0]  ticker_index;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic        risk_allowed;
        logic [2:0]  response_type;
        logic [31:0] remain_qty;
    } t_in_item;

    typedef struct packed {
        logic        request_kind;
        logic [31:0] order_id;
        logic [2:0]  req_ticker;
        logic        req_side;
        logic [31:0] req_price;
        logic [31:0] req_quantity;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] order_id;
        logic [31:0] price;
        logic [31:0] quantity;
    } t_slot;

endpackage

`default_nettype wire

// ===== src/order_slot_state_manager.sv =====
// ----------------------------------------------------------------------------
// order_slot_state_manager
// Keeps one order slot per instrument and side in a synchronous slot memory
// and turns strategy moves into new/cancel requests; exchange responses
// update the slot in place.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------
//  input     | in        | i_in_valid / o_in_stall    | i_in_item
//  output    | out       | o_out_valid / i_out_stall  | o_out_item
//
//  An accepted item's slot is read from the slot memory into r_rdata; the
//  execute step then applies the update, writes the slot back and, if a
//  request results, loads the output register.
//  The execute step waits while a full output register is stalled; a new
//  item is still taken while a finished result waits in the output register.
//  After reset a clearing pass zeroes all 2*NUM_TICKERS slots of the memory;
//  o_in_stall stays high until it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module order_slot_state_manager
    import ossm_pkg::*;
#(
    parameter int NUM_TICKERS = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int NUM_SLOTS = 2 * NUM_TICKERS;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IDX_W     = (SLOT_W > 4) ? SLOT_W : 4;
    localparam logic [8:0]        NT_LIMIT  = 9'(NUM_TICKERS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    // Control states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [SLOT_W-1:0] r_clr_idx;
    logic [31:0]       r_next_id;
    logic [31:0]       n_next_id;
    t_in_item          r_item;
    logic              r_in_range;
    logic [SLOT_W-1:0] r_slot_idx;
    logic              r_out_valid;
    t_out_item         r_out_item;

    // Slot memory
    t_slot             r_mem [NUM_SLOTS];
    t_slot             r_rdata;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    t_slot             mem_wdata;

    logic              in_accept;
    logic              in_range;
    logic [IDX_W-1:0]  idx_wide;
    logic [SLOT_W-1:0] in_slot_idx;
    logic              can_load;
    logic              commit;
    logic              emit;
    t_out_item         n_out;
    t_slot             n_slot;

    // Decode the addressed slot of an incoming item
    assign in_range    = ({6'd0, i_in_item.ticker_index} < NT_LIMIT);
    assign idx_wide    = IDX_W'({i_in_item.ticker_index, i_in_item.side});
    assign in_slot_idx = idx_wide[SLOT_W-1:0];

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign can_load   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == S_EXEC) && can_load;

    // Apply the move or the response to the slot read from memory
    always_comb begin
        n_slot    = r_rdata;
        n_next_id = r_next_id;
        emit      = 1'b0;
        n_out     = '0;
        if (r_item.func == FUNC_MOVE) begin
            if (r_rdata.status == SLOT_LIVE) begin
                if ((r_rdata.price != r_item.price)
                        || (r_rdata.quantity != r_item.quantity)) begin
                    emit               = 1'b1;
                    n_out.request_kind = REQ_CANCEL;
                    n_out.order_id     = r_rdata.order_id;
                    n_out.req_ticker   = r_item.ticker_index;
                    n_out.req_side     = r_item.side;
                    n_out.req_price    = r_rdata.price;
                    n_out.req_quantity = r_rdata.quantity;
                    n_slot.status      = SLOT_PENDING_CANCEL;
                end
            end else if ((r_rdata.status == SLOT_INVALID)
                    || (r_rdata.status == SLOT_DEAD)) begin
                if ((r_item.price != NO_PRICE) && r_item.risk_allowed) begin
                    emit               = 1'b1;
                    n_out.request_kind = REQ_NEW;
                    n_out.order_id     = r_next_id;
                    n_out.req_ticker   = r_item.ticker_index;
                    n_out.req_side     = r_item.side;
                    n_out.req_price    = r_item.price;
                    n_out.req_quantity = r_item.quantity;
                    n_slot.status      = SLOT_PENDING_NEW;
                    n_slot.order_id    = r_next_id;
                    n_slot.price       = r_item.price;
                    n_slot.quantity    = r_item.quantity;
                    n_next_id          = r_next_id + 32'd1;
                end
            end
        end else begin
            case (r_item.response_type)
                RSP_ACCEPTED: begin
                    n_slot.status = SLOT_LIVE;
                end
                RSP_CANCELED: begin
                    n_slot.status   = SLOT_DEAD;
                    n_slot.quantity = r_item.remain_qty;
                end
                RSP_FILLED: begin
                    n_slot.quantity = r_item.remain_qty;
                    if (r_item.remain_qty == 32'd0) begin
                        n_slot.status = SLOT_DEAD;
                    end
                end
                default: begin
                    n_slot = r_rdata;
                end
            endcase
        end
        // Drop items for instruments beyond the configured count
        if (!r_in_range) begin
            n_slot    = r_rdata;
            n_next_id = r_next_id;
            emit      = 1'b0;
        end
    end

    // Memory write port: clearing pass, then write-back at commit
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = '0;
        end else begin
            mem_we    = commit && r_in_range;
            mem_waddr = r_slot_idx;
            mem_wdata = n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_rdata <= r_mem[in_slot_idx];
        end
    end

    // Next control state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_next_id   <= FIRST_ORDER_ID;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + SLOT_W'(1);
            end
            if (commit) begin
                r_next_id <= n_next_id;
            end
            if (commit && emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the accepted item and load the result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item     <= i_in_item;
            r_in_range <= in_range;
            r_slot_idx <= in_slot_idx;
        end
        if (commit && emit) begin
            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
